FILE: rtl/rc4iv_pkg.sv
// Shared types and constants for the RC4 cipher with per-message IV.
package rc4iv_pkg;

    localparam int KEY_MAX_BYTES = 48;
    localparam int IV_BYTES      = 6;

    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int IV_W        = IV_BYTES * BYTE_W;
    localparam int KLEN_W      = 6;
    localparam int KEY_WORD_W  = 64;
    localparam int KEY_WORDS   = 6;
    localparam int VCNT_W      = $clog2(KEY_MAX_BYTES + IV_BYTES);
    localparam int HDR_CNT_W   = $clog2(IV_BYTES + 1);
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 3;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0  = 3'd1;

    // request operation codes
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd0;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA    = 2'd2;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_START,
        CMD_DATA,
        CMD_FILL,
        CMD_K_RDI,
        CMD_K_RDJ,
        CMD_K_WRI,
        CMD_K_WRJ,
        CMD_P_RDI,
        CMD_P_RDJ,
        CMD_P_WRI,
        CMD_P_WRJ,
        CMD_P_RDT,
        CMD_P_OUT,
        CMD_HDR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic i_last;    // stream index i at 255
        logic hdr_last;  // current header byte is the final one
        logic out_free;  // output register can take a result this cycle
    } t_dp_stat;

endpackage

FILE: rtl/rc4_stream_cipher_with_iv_top.sv
// RC4 stream cipher keyed per message by the configured key and a 48-bit IV.
//
// Config: write key_length (index 0) and key words (1..6) while the block is idle.
// Input channel (i_in_valid / o_in_stall) takes one request at a time:
//   start encrypt, start decrypt or data byte. Unused opcode 3 is dropped.
// A start request rebuilds the 256-entry table: an identity fill, then 256 schedule
//   steps that each read S[i] and S[j] and write both back through the single
//   write port of the table RAM. An encrypt start then emits the six IV header
//   bytes, most significant first, one per cycle while the output register is free.
// A data request steps through two table reads, two writes for the swap,
//   the keystream read and the output load, which waits for a free output
//   register; the reads share one read port. The next request is taken once
//   the result is loaded, so a new data request waits for the last one.
// Output channel (o_out_valid / i_out_stall) has one result register; a new
//   request is taken while a result still waits. When the receiver stalls,
//   the result holds and the block waits with its next result.
// After reset the table is filled with the identity in one pass, during
//   which o_in_stall stays high; config writes are taken at any time.
module rc4_stream_cipher_with_iv_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rc4iv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rc4iv_pkg::KEY_WORD_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [rc4iv_pkg::OP_W-1:0]            i_operation,
    input  logic [rc4iv_pkg::IV_W-1:0]            i_iv,
    input  logic [rc4iv_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                  i_end_of_message,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [rc4iv_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                  o_is_header,
    output logic                                  o_last_of_run
);

    rc4iv_pkg::t_dp_cmd  cmd;
    rc4iv_pkg::t_dp_stat stat;

    rc4iv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_operation(i_operation),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    rc4iv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_iv            (i_iv),
        .i_data_byte     (i_data_byte),
        .i_end_of_message(i_end_of_message),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_is_header     (o_is_header),
        .o_last_of_run   (o_last_of_run)
    );

    // the identity fill runs right after reset
    a_fill_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input not stalled during post-reset table fill");

    // a start request always begins a fill pass
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_operation == rc4iv_pkg::OP_ENCRYPT || i_operation == rc4iv_pkg::OP_DECRYPT))
        |=> (o_in_stall && cmd.op == rc4iv_pkg::CMD_FILL))
        else $error("start request did not begin the table fill");

    // a data request occupies the table for several cycles
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_operation == rc4iv_pkg::OP_DATA)
        |=> o_in_stall ##1 o_in_stall)
        else $error("data request released the input too early");

    // a result is loaded only when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == rc4iv_pkg::CMD_P_OUT || cmd.op == rc4iv_pkg::CMD_HDR)
        |-> (!o_out_valid || !i_out_stall))
        else $error("pending result overwritten");

endmodule

FILE: rtl/rc4iv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rc4iv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rc4iv_dp.sv
// Datapath: key registers, permutation table, stream indices and output register.
module rc4iv_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rc4iv_pkg::t_dp_cmd                    i_cmd,
    output rc4iv_pkg::t_dp_stat                   o_stat,
    input  logic                                  i_cfg_we,
    input  logic [rc4iv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rc4iv_pkg::KEY_WORD_W-1:0]      i_cfg_data,
    input  logic [rc4iv_pkg::IV_W-1:0]            i_iv,
    input  logic [rc4iv_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                  i_end_of_message,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic [rc4iv_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                  o_is_header,
    output logic                                  o_last_of_run
);

    logic [rc4iv_pkg::KLEN_W-1:0]     r_key_length;
    logic [rc4iv_pkg::KEY_WORD_W-1:0] r_key [0:rc4iv_pkg::KEY_WORDS-1];

    logic [rc4iv_pkg::IDX_W-1:0]     r_i, n_i;
    logic [rc4iv_pkg::IDX_W-1:0]     r_j, n_j;
    logic [rc4iv_pkg::VCNT_W-1:0]    r_v, n_v;
    logic [rc4iv_pkg::HDR_CNT_W-1:0] r_hdr, n_hdr;
    logic [rc4iv_pkg::KLEN_W-1:0]    r_klen;
    logic                            r_empty;
    logic [rc4iv_pkg::IV_W-1:0]      r_iv;
    logic [rc4iv_pkg::BYTE_W-1:0]    r_data;
    logic                            r_eom;
    logic [rc4iv_pkg::BYTE_W-1:0]    r_kb;
    logic [rc4iv_pkg::BYTE_W-1:0]    r_si;
    logic [rc4iv_pkg::BYTE_W-1:0]    r_sj;

    logic                            r_out_valid;
    logic [rc4iv_pkg::BYTE_W-1:0]    r_out_byte;
    logic                            r_is_header;
    logic                            r_last_of_run;

    logic                            ram_we;
    logic [rc4iv_pkg::IDX_W-1:0]     ram_waddr;
    logic [rc4iv_pkg::BYTE_W-1:0]    ram_wdata;
    logic                            ram_re;
    logic [rc4iv_pkg::IDX_W-1:0]     ram_raddr;
    logic [rc4iv_pkg::BYTE_W-1:0]    ram_rdata;

    logic [rc4iv_pkg::KLEN_W-1:0]    klen_eff;
    logic [rc4iv_pkg::BYTE_W-1:0]    kb;
    logic [rc4iv_pkg::BYTE_W-1:0]    j_ksa;
    logic [rc4iv_pkg::BYTE_W-1:0]    j_prga;
    logic [rc4iv_pkg::BYTE_W-1:0]    i_next;
    logic                            v_wrap;
    logic                            out_free;
    logic                            out_load;
    logic [rc4iv_pkg::BYTE_W-1:0]    load_byte;
    logic                            load_hdr;
    logic                            load_last;

    // header byte k, most significant first
    function automatic logic [rc4iv_pkg::BYTE_W-1:0] iv_byte(
        input logic [rc4iv_pkg::IV_W-1:0]   iv,
        input logic [rc4iv_pkg::VCNT_W-1:0] k
    );
        logic [rc4iv_pkg::BYTE_W-1:0] b;
        b = '0;
        for (int n = 0; n < rc4iv_pkg::IV_BYTES; n++) begin
            if (k == rc4iv_pkg::VCNT_W'(n)) begin
                b = iv[rc4iv_pkg::BYTE_W*(rc4iv_pkg::IV_BYTES-1-n) +: rc4iv_pkg::BYTE_W];
            end
        end
        return b;
    endfunction

    rc4iv_ram #(
        .WIDTH(rc4iv_pkg::BYTE_W),
        .DEPTH(rc4iv_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // empty key runs as one zero byte; oversized lengths saturate
    always_comb begin
        if (r_key_length == '0) begin
            klen_eff = rc4iv_pkg::KLEN_W'(1);
        end else if (r_key_length > rc4iv_pkg::KLEN_W'(rc4iv_pkg::KEY_MAX_BYTES)) begin
            klen_eff = rc4iv_pkg::KLEN_W'(rc4iv_pkg::KEY_MAX_BYTES);
        end else begin
            klen_eff = r_key_length;
        end
    end

    // virtual key byte at schedule position r_v
    always_comb begin
        logic [2:0] widx;
        widx = r_v[5:3];
        kb   = '0;
        if (r_v < rc4iv_pkg::VCNT_W'(r_klen)) begin
            if (!r_empty && widx < 3'(rc4iv_pkg::KEY_WORDS)) begin
                kb = r_key[widx][{r_v[2:0], 3'b000} +: rc4iv_pkg::BYTE_W];
            end
        end else begin
            kb = iv_byte(r_iv, r_v - rc4iv_pkg::VCNT_W'(r_klen));
        end
    end

    assign v_wrap = (r_v ==
                     (rc4iv_pkg::VCNT_W'(r_klen) + rc4iv_pkg::VCNT_W'(rc4iv_pkg::IV_BYTES - 1)));
    assign j_ksa  = r_j + ram_rdata + r_kb;
    assign j_prga = r_j + ram_rdata;
    assign i_next = r_i + 1'b1;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_i       = r_i;
        n_j       = r_j;
        n_v       = r_v;
        n_hdr     = r_hdr;
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_i;
        out_load  = 1'b0;
        load_byte = r_data ^ ram_rdata;
        load_hdr  = 1'b0;
        load_last = r_eom;
        unique case (i_cmd.op)
            rc4iv_pkg::CMD_IDLE, rc4iv_pkg::CMD_DATA: begin
            end
            rc4iv_pkg::CMD_START: begin
                n_i   = '0;
                n_j   = '0;
                n_v   = '0;
                n_hdr = '0;
            end
            rc4iv_pkg::CMD_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_i;
                n_i       = i_next;
            end
            rc4iv_pkg::CMD_K_RDI: begin
                ram_re = 1'b1;
            end
            rc4iv_pkg::CMD_K_RDJ: begin
                ram_re    = 1'b1;
                ram_raddr = j_ksa;
                n_j       = j_ksa;
            end
            rc4iv_pkg::CMD_K_WRI: begin
                ram_we = 1'b1;
            end
            rc4iv_pkg::CMD_K_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
                n_i       = i_next;
                n_v       = v_wrap ? '0 : r_v + 1'b1;
                // stream indices restart from zero once the schedule ends
                if (r_i == '1) begin
                    n_j = '0;
                end
            end
            rc4iv_pkg::CMD_P_RDI: begin
                ram_re    = 1'b1;
                ram_raddr = i_next;
                n_i       = i_next;
            end
            rc4iv_pkg::CMD_P_RDJ: begin
                ram_re    = 1'b1;
                ram_raddr = j_prga;
                n_j       = j_prga;
            end
            rc4iv_pkg::CMD_P_WRI: begin
                ram_we = 1'b1;
            end
            rc4iv_pkg::CMD_P_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_si;
            end
            rc4iv_pkg::CMD_P_RDT: begin
                ram_re    = 1'b1;
                ram_raddr = r_si + r_sj;
            end
            rc4iv_pkg::CMD_P_OUT: begin
                out_load = 1'b1;
            end
            rc4iv_pkg::CMD_HDR: begin
                out_load  = 1'b1;
                load_byte = iv_byte(r_iv, rc4iv_pkg::VCNT_W'(r_hdr));
                load_hdr  = 1'b1;
                load_last = (r_hdr == rc4iv_pkg::HDR_CNT_W'(rc4iv_pkg::IV_BYTES - 1));
                n_hdr     = r_hdr + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            for (int w = 0; w < rc4iv_pkg::KEY_WORDS; w++) begin
                r_key[w] <= '0;
            end
            r_i         <= '0;
            r_j         <= '0;
            r_v         <= '0;
            r_hdr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rc4iv_pkg::CFG_KEY_LENGTH) begin
                    r_key_length <= i_cfg_data[rc4iv_pkg::KLEN_W-1:0];
                end else if (i_cfg_index >= rc4iv_pkg::CFG_KEY_WORD0 &&
                             i_cfg_index <  rc4iv_pkg::CFG_KEY_WORD0 +
                                            rc4iv_pkg::CFG_IDX_W'(rc4iv_pkg::KEY_WORDS)) begin
                    r_key[i_cfg_index - rc4iv_pkg::CFG_KEY_WORD0] <= i_cfg_data;
                end
            end
            r_i   <= n_i;
            r_j   <= n_j;
            r_v   <= n_v;
            r_hdr <= n_hdr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rc4iv_pkg::CMD_START) begin
            r_iv    <= i_iv;
            r_klen  <= klen_eff;
            r_empty <= (r_key_length == '0);
        end
        if (i_cmd.op == rc4iv_pkg::CMD_DATA) begin
            r_data <= i_data_byte;
            r_eom  <= i_end_of_message;
        end
        if (i_cmd.op == rc4iv_pkg::CMD_K_RDI) begin
            r_kb <= kb;
        end
        if (i_cmd.op == rc4iv_pkg::CMD_K_RDJ || i_cmd.op == rc4iv_pkg::CMD_P_RDJ) begin
            r_si <= ram_rdata;
        end
        if (i_cmd.op == rc4iv_pkg::CMD_P_WRI) begin
            r_sj <= ram_rdata;
        end
        if (out_load) begin
            r_out_byte    <= load_byte;
            r_is_header   <= load_hdr;
            r_last_of_run <= load_last;
        end
    end

    assign o_stat.i_last   = (r_i == '1);
    assign o_stat.hdr_last = (r_hdr == rc4iv_pkg::HDR_CNT_W'(rc4iv_pkg::IV_BYTES - 1));
    assign o_stat.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_is_header   = r_is_header;
    assign o_last_of_run = r_last_of_run;

endmodule

FILE: rtl/rc4iv_ctrl.sv
// Controller: sequences table fill, key schedule, keystream steps and header bytes.
module rc4iv_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic [rc4iv_pkg::OP_W-1:0]     i_operation,
    output logic                           o_in_stall,
    output rc4iv_pkg::t_dp_cmd             o_cmd,
    input  rc4iv_pkg::t_dp_stat            i_stat
);

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_K_RDI,
        ST_K_RDJ,
        ST_K_WRI,
        ST_K_WRJ,
        ST_P_RDI,
        ST_P_RDJ,
        ST_P_WRI,
        ST_P_WRJ,
        ST_P_RDT,
        ST_P_OUT,
        ST_HDR
    } t_state;

    t_state r_state, n_state;
    logic   r_ksa, n_ksa;   // key schedule follows the fill pass
    logic   r_enc, n_enc;   // header bytes follow the key schedule

    always_comb begin
        n_state  = r_state;
        n_ksa    = r_ksa;
        n_enc    = r_enc;
        o_cmd.op = rc4iv_pkg::CMD_IDLE;
        unique case (r_state)
            ST_FILL: begin
                o_cmd.op = rc4iv_pkg::CMD_FILL;
                if (i_stat.i_last) begin
                    n_state = r_ksa ? ST_K_RDI : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_operation == rc4iv_pkg::OP_ENCRYPT ||
                                 i_operation == rc4iv_pkg::OP_DECRYPT) begin
                        o_cmd.op = rc4iv_pkg::CMD_START;
                        n_state  = ST_FILL;
                        n_ksa    = 1'b1;
                        n_enc    = (i_operation == rc4iv_pkg::OP_ENCRYPT);
                    end else if (i_operation == rc4iv_pkg::OP_DATA) begin
                        o_cmd.op = rc4iv_pkg::CMD_DATA;
                        n_state  = ST_P_RDI;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_K_RDI: begin
                o_cmd.op = rc4iv_pkg::CMD_K_RDI;
                n_state  = ST_K_RDJ;
            end
            ST_K_RDJ: begin
                o_cmd.op = rc4iv_pkg::CMD_K_RDJ;
                n_state  = ST_K_WRI;
            end
            ST_K_WRI: begin
                o_cmd.op = rc4iv_pkg::CMD_K_WRI;
                n_state  = ST_K_WRJ;
            end
            ST_K_WRJ: begin
                o_cmd.op = rc4iv_pkg::CMD_K_WRJ;
                if (i_stat.i_last) begin
                    n_ksa   = 1'b0;
                    n_state = r_enc ? ST_HDR : ST_IDLE;
                end else begin
                    n_state = ST_K_RDI;
                end
            end
            ST_P_RDI: begin
                o_cmd.op = rc4iv_pkg::CMD_P_RDI;
                n_state  = ST_P_RDJ;
            end
            ST_P_RDJ: begin
                o_cmd.op = rc4iv_pkg::CMD_P_RDJ;
                n_state  = ST_P_WRI;
            end
            ST_P_WRI: begin
                o_cmd.op = rc4iv_pkg::CMD_P_WRI;
                n_state  = ST_P_WRJ;
            end
            ST_P_WRJ: begin
                o_cmd.op = rc4iv_pkg::CMD_P_WRJ;
                n_state  = ST_P_RDT;
            end
            ST_P_RDT: begin
                o_cmd.op = rc4iv_pkg::CMD_P_RDT;
                n_state  = ST_P_OUT;
            end
            ST_P_OUT: begin
                // table read data holds until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.op = rc4iv_pkg::CMD_P_OUT;
                    n_state  = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = rc4iv_pkg::CMD_HDR;
                    if (i_stat.hdr_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_ksa   <= 1'b0;
            r_enc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ksa   <= n_ksa;
            r_enc   <= n_enc;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
